// File: sv/zmru_pkg.sv
// Shared types and constants for the Z-machine story memory unit.
// Depends on nothing; the memory region unit core imports this package.
`timescale 1ns / 1ps

package zmru_pkg;

  // Story store size in bytes, split into an even and an odd byte bank.
  localparam int MEM_BYTES  = 262144;
  localparam int BANK_DEPTH = MEM_BYTES / 2;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  // Field widths of a request and a result.
  localparam int KIND_W = 3;
  localparam int ADDR_W = 18;
  localparam int DATA_W = 16;
  localparam int STAT_W = 2;

  // Effective byte address: a packed address shifted by two, plus one for
  // the second byte of a word.
  localparam int EA_W = ADDR_W + 3;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_LOAD    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RD_BYTE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RD_WORD = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WR_BYTE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_WR_WORD = 3'd4;
  localparam logic [KIND_W-1:0] KIND_RD_GLOB = 3'd5;
  localparam logic [KIND_W-1:0] KIND_WR_GLOB = 3'd6;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_RD_OOB  = 2'd1;
  localparam logic [STAT_W-1:0] ST_WR_OOB  = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_VER = 2'd3;

  // Configuration register indexes (byte address is four times the index).
  localparam logic [2:0] REG_DYNAMIC_END   = 3'd0;
  localparam logic [2:0] REG_HIGH_START    = 3'd1;
  localparam logic [2:0] REG_IMAGE_LENGTH  = 3'd2;
  localparam logic [2:0] REG_STORY_VERSION = 3'd3;
  localparam logic [2:0] REG_GLOBALS_BASE  = 3'd4;

  // Configuration reset values.
  localparam logic [15:0] DYNAMIC_END_RST   = 16'd64;
  localparam logic [15:0] HIGH_START_RST    = 16'd0;
  localparam logic [18:0] IMAGE_LENGTH_RST  = 19'd64;
  localparam logic [3:0]  STORY_VERSION_RST = 4'd3;
  localparam logic [15:0] GLOBALS_BASE_RST  = 16'd0;

  // Version limits for packed address shifts.
  localparam logic [3:0] VER_SHIFT1_MAX = 4'd3;
  localparam logic [3:0] VER_SHIFT2_MAX = 4'd5;

  // Global variable numbers and the end of the 16-bit static window.
  localparam logic [ADDR_W-1:0] GLOBAL_FIRST = 18'h10;
  localparam logic [ADDR_W-1:0] GLOBAL_LAST  = 18'hff;
  localparam logic [EA_W-1:0]   STATIC_LIMIT = 21'h10000;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADDR,
    S_EXEC,
    S_READ
  } state_t;

endpackage

// File: sv/zmru_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// Depends on nothing; used for the two story byte banks.
`timescale 1ns / 1ps

module zmru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

// File: sv/zmachine_memory_region_unit_core.sv
// Z-machine story memory unit: loads, writes, unused kinds and failed
// accesses pass through the address stage and the check stage to the result
// register; reads also wait in a RAM read state. A new request is taken once
// the previous one has left its result in the output register; the check
// stage holds while the output register is full and not being taken.
// Reset clears the control state and restores the configuration defaults;
// story memory contents are undefined until written.
`timescale 1ns / 1ps

module zmachine_memory_region_unit_core
  import zmru_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Request stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // address[17:0], write_data[33:18], zero pad
  input  logic [3:0]  s_tuser,   // kind[2:0], packed_req[3]
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // read_data[15:0], status[17:16], zero pad
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic [15:0] dynamic_end;
  logic [15:0] high_start;
  logic [18:0] image_length;
  logic [3:0]  story_version;
  logic [15:0] globals_base;

  // Request held while it is worked on.
  state_t              state;
  state_t              state_next;
  logic [KIND_W-1:0]   kind_q;
  logic                packed_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [DATA_W-1:0]   wdata_q;
  logic [EA_W-1:0]     ea_q;
  logic [STAT_W-1:0]   stat_q;

  // Result register.
  logic [DATA_W-1:0]   rd_q;
  logic [STAT_W-1:0]   st_q;

  // Address stage.
  logic [EA_W-1:0]     ea_next;
  logic [STAT_W-1:0]   stat_next;
  logic [ADDR_W-1:0]   glob_off;
  logic                is_packed_kind;

  // Check stage.
  logic [EA_W-1:0]     len_eff;
  logic [EA_W-1:0]     stat_end;
  logic [EA_W-1:0]     ea1;
  logic                rd_ok0;
  logic                rd_ok1;
  logic                wr_ok0;
  logic                wr_ok1;
  logic                is_word;
  logic [STAT_W-1:0]   stat_exec;
  logic                exec_read;
  logic                exec_write;
  logic                out_free;
  logic                cfg_wr;

  // Memory controls.
  logic                ev_en;
  logic                od_en;
  logic [BANK_AW-1:0]  ev_addr;
  logic [BANK_AW-1:0]  od_addr;
  logic [7:0]          ev_wdata;
  logic [7:0]          od_wdata;
  logic [7:0]          ev_rdata;
  logic [7:0]          od_rdata;
  logic                load_result;
  logic                result_from_mem;
  logic [DATA_W-1:0]   mem_word;

  function automatic logic can_write(input logic [EA_W-1:0] a,
                                     input logic [15:0]     dyn_end);
    can_write = (a < EA_W'(dyn_end)) && (a < EA_W'(MEM_BYTES));
  endfunction

  function automatic logic can_read(input logic [EA_W-1:0] a,
                                    input logic [15:0]     dyn_end,
                                    input logic [15:0]     hi_start,
                                    input logic [EA_W-1:0] len,
                                    input logic [EA_W-1:0] s_end);
    logic dyn_hit;
    logic stat_hit;
    logic high_hit;
    dyn_hit  = (a < EA_W'(dyn_end)) && (a < EA_W'(MEM_BYTES));
    stat_hit = (a >= EA_W'(dyn_end)) && (a < s_end);
    high_hit = (a >= EA_W'(hi_start)) && (a < len);
    can_read = dyn_hit || stat_hit || high_hit;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration port. Writes land on the access cycle; reads are direct.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dynamic_end   <= DYNAMIC_END_RST;
      high_start    <= HIGH_START_RST;
      image_length  <= IMAGE_LENGTH_RST;
      story_version <= STORY_VERSION_RST;
      globals_base  <= GLOBALS_BASE_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_DYNAMIC_END:   dynamic_end   <= pwdata[15:0];
        REG_HIGH_START:    high_start    <= pwdata[15:0];
        REG_IMAGE_LENGTH:  image_length  <= pwdata[18:0];
        REG_STORY_VERSION: story_version <= pwdata[3:0];
        REG_GLOBALS_BASE:  globals_base  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_DYNAMIC_END:   prdata = {16'd0, dynamic_end};
      REG_HIGH_START:    prdata = {16'd0, high_start};
      REG_IMAGE_LENGTH:  prdata = {13'd0, image_length};
      REG_STORY_VERSION: prdata = {28'd0, story_version};
      REG_GLOBALS_BASE:  prdata = {16'd0, globals_base};
      default:           prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Address stage: unpack a packed address, locate a global variable, and
  // flag a bad version or a variable number outside the table.
  // ---------------------------------------------------------------------------
  assign is_packed_kind = (kind_q == KIND_RD_BYTE) || (kind_q == KIND_RD_WORD) ||
                          (kind_q == KIND_WR_BYTE) || (kind_q == KIND_WR_WORD);
  assign glob_off = addr_q - GLOBAL_FIRST;

  always_comb begin
    ea_next   = EA_W'(addr_q);
    stat_next = ST_OK;
    if (is_packed_kind && packed_q) begin
      if (story_version <= VER_SHIFT1_MAX) begin
        ea_next = EA_W'({addr_q, 1'b0});
      end else if (story_version <= VER_SHIFT2_MAX) begin
        ea_next = EA_W'({addr_q, 2'b00});
      end else begin
        stat_next = ST_BAD_VER;
      end
    end
    if ((kind_q == KIND_RD_GLOB) || (kind_q == KIND_WR_GLOB)) begin
      ea_next = EA_W'(globals_base) + EA_W'({glob_off[7:0], 1'b0});
      if ((addr_q < GLOBAL_FIRST) || (addr_q > GLOBAL_LAST)) begin
        stat_next = (kind_q == KIND_RD_GLOB) ? ST_RD_OOB : ST_WR_OOB;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Check stage: region checks on the effective address and its successor.
  // The image length is clipped to the store size, and static memory also
  // ends at the top of the 16-bit address space.
  // ---------------------------------------------------------------------------
  assign len_eff  = (EA_W'(image_length) < EA_W'(MEM_BYTES)) ?
                    EA_W'(image_length) : EA_W'(MEM_BYTES);
  assign stat_end = (len_eff < STATIC_LIMIT) ? len_eff : STATIC_LIMIT;
  assign ea1      = ea_q + EA_W'(1);

  assign rd_ok0 = can_read(ea_q, dynamic_end, high_start, len_eff, stat_end);
  assign rd_ok1 = can_read(ea1, dynamic_end, high_start, len_eff, stat_end);
  assign wr_ok0 = can_write(ea_q, dynamic_end);
  assign wr_ok1 = can_write(ea1, dynamic_end);

  assign is_word = (kind_q == KIND_RD_WORD) || (kind_q == KIND_WR_WORD) ||
                   (kind_q == KIND_RD_GLOB) || (kind_q == KIND_WR_GLOB);

  always_comb begin
    stat_exec  = stat_q;
    exec_read  = 1'b0;
    exec_write = 1'b0;
    if (stat_q == ST_OK) begin
      case (kind_q)
        KIND_LOAD: begin
          exec_write = ea_q < EA_W'(MEM_BYTES);
        end
        KIND_RD_BYTE: begin
          if (rd_ok0) exec_read = 1'b1;
          else        stat_exec = ST_RD_OOB;
        end
        KIND_RD_WORD, KIND_RD_GLOB: begin
          if (rd_ok0 && rd_ok1) exec_read = 1'b1;
          else                  stat_exec = ST_RD_OOB;
        end
        KIND_WR_BYTE: begin
          if (wr_ok0) exec_write = 1'b1;
          else        stat_exec  = ST_WR_OOB;
        end
        KIND_WR_WORD, KIND_WR_GLOB: begin
          if (wr_ok0 && wr_ok1) exec_write = 1'b1;
          else                  stat_exec  = ST_WR_OOB;
        end
        default: ;
      endcase
    end
  end

  // The result register is free when empty or when its result leaves now.
  assign out_free = !m_tvalid || m_tready;

  // ---------------------------------------------------------------------------
  // Sequencer: accept, form the address, check and access, collect read data.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (s_tvalid) state_next = S_ADDR;
      S_ADDR: state_next = S_EXEC;
      S_EXEC: begin
        if (out_free) begin
          state_next = exec_read ? S_READ : S_IDLE;
        end
      end
      S_READ: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // A word touches byte a and a+1, which always sit in different banks.
  // The odd bank is indexed by a/2 in every case; the even bank by (a+1)/2
  // when an odd-aligned word needs its low byte from there.
  always_comb begin
    s_tready        = 1'b0;
    ev_en           = 1'b0;
    od_en           = 1'b0;
    load_result     = 1'b0;
    result_from_mem = 1'b0;
    ev_addr         = ea_q[BANK_AW:1];
    od_addr         = ea_q[BANK_AW:1];
    ev_wdata        = wdata_q[7:0];
    od_wdata        = wdata_q[7:0];
    if (is_word && ea_q[0]) begin
      ev_addr = ea1[BANK_AW:1];
    end
    if (is_word) begin
      ev_wdata = ea_q[0] ? wdata_q[7:0] : wdata_q[15:8];
      od_wdata = ea_q[0] ? wdata_q[15:8] : wdata_q[7:0];
    end
    case (state)
      S_IDLE: s_tready = 1'b1;
      S_EXEC: begin
        if (out_free && (exec_read || exec_write)) begin
          ev_en = is_word || !ea_q[0];
          od_en = is_word || ea_q[0];
        end
        load_result = out_free && !exec_read;
      end
      S_READ: begin
        load_result     = 1'b1;
        result_from_mem = 1'b1;
      end
      default: ;
    endcase
  end

  // Big-endian word: the byte at the lower address is the high byte.
  always_comb begin
    if (is_word) begin
      mem_word = ea_q[0] ? {od_rdata, ev_rdata} : {ev_rdata, od_rdata};
    end else begin
      mem_word = {8'd0, (ea_q[0] ? od_rdata : ev_rdata)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_result) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      kind_q   <= s_tuser[2:0];
      packed_q <= s_tuser[3];
      addr_q   <= s_tdata[17:0];
      wdata_q  <= s_tdata[33:18];
    end
    if (state == S_ADDR) begin
      ea_q   <= ea_next;
      stat_q <= stat_next;
    end
    if (load_result) begin
      if (result_from_mem) begin
        rd_q <= mem_word;
        st_q <= ST_OK;
      end else begin
        rd_q <= '0;
        st_q <= stat_exec;
      end
    end
  end

  assign m_tdata = {6'd0, st_q, rd_q};

  // ---------------------------------------------------------------------------
  // Story store: even and odd byte banks.
  // ---------------------------------------------------------------------------
  zmru_ram #(
    .WIDTH(8),
    .DEPTH(BANK_DEPTH)
  ) u_even_bank (
    .clk  (clk),
    .en   (ev_en),
    .we   (exec_write),
    .addr (ev_addr),
    .wdata(ev_wdata),
    .rdata(ev_rdata)
  );

  zmru_ram #(
    .WIDTH(8),
    .DEPTH(BANK_DEPTH)
  ) u_odd_bank (
    .clk  (clk),
    .en   (od_en),
    .we   (exec_write),
    .addr (od_addr),
    .wdata(od_wdata),
    .rdata(od_rdata)
  );

endmodule
